// ===== hdl/iirq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iirq_pkg;

    localparam int POS_BITS    = 5;
    localparam int OCC_BITS    = 5;
    localparam int IN_WORD_BITS  = 32;
    localparam int OUT_WORD_BITS = 32;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_INSERT  = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // datapath command for one accepted word
    typedef struct packed {
        logic shift_in;   // open a gap at cmd position and write the word
        logic shift_out;  // close the gap at cmd position
    } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/iirq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iirq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire iirq_pkg::op_t                        op,
    input  wire logic [iirq_pkg::POS_BITS-1:0]        position,
    input  wire logic [$clog2(DEPTH+1)-1:0]           count,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output iirq_pkg::status_t                         status,
    output iirq_pkg::cmd_t                            cmd,
    output logic [$clog2(DEPTH)-1:0]                  cmd_pos
);
    import iirq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic    state_reg, state_next;
    status_t status_reg, status_next;
    logic    accept;
    logic    is_empty, is_full;
    logic [CMPW-1:0] pos_w, cnt_w;
    cmd_t    cmd_raw;
    logic [IW-1:0] pos_raw;

    assign is_empty = (count == '0);
    assign is_full  = (count == CW'(DEPTH));
    assign pos_w    = CMPW'(position);
    assign cnt_w    = CMPW'(count);

    // a pending result is freed in the same cycle it is taken
    assign s_tready = (state_reg == S_IDLE) || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd_raw     = '0;
        pos_raw     = '0;
        status_next = STAT_OK;
        unique case (op)
            OP_ENQUEUE: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    cmd_raw.shift_in = 1'b1;
                    pos_raw = IW'(count);
                end
            end
            OP_DEQUEUE: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    cmd_raw.shift_out = 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos_w > cnt_w) begin
                    status_next = STAT_RANGE;
                end else if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    cmd_raw.shift_in = 1'b1;
                    pos_raw = IW'(position);
                end
            end
            OP_REMOVE: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    status_next = STAT_RANGE;
                end else begin
                    cmd_raw.shift_out = 1'b1;
                    pos_raw = IW'(position);
                end
            end
            default: status_next = STAT_OK;
        endcase
    end

    assign cmd     = accept ? cmd_raw : '0;
    assign cmd_pos = pos_raw;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_RESULT;
            S_RESULT: if (m_tready && !accept) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    assign m_tvalid = (state_reg == S_RESULT);
    assign status   = status_reg;

endmodule
`default_nettype wire

// ===== hdl/iirq_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iirq_dpath #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire iirq_pkg::cmd_t                         cmd,
    input  wire logic [$clog2(DEPTH)-1:0]               cmd_pos,
    input  wire logic [iirq_pkg::IN_WORD_BITS-1:0]      item_word,
    output logic [$clog2(DEPTH+1)-1:0]                  count,
    output logic [iirq_pkg::OUT_WORD_BITS-1:0]          head_word,
    output logic [iirq_pkg::OUT_WORD_BITS-1:0]          tail_word
);
    import iirq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [WORD_BITS-1:0] cell_reg [DEPTH];
    logic [WORD_BITS-1:0] cell_next [DEPTH];
    logic [CW-1:0]        count_reg, count_next;
    logic [WORD_BITS-1:0] word_in;
    logic [IW-1:0]        tail_idx;
    logic [63:0]          head_ext, tail_ext;

    assign word_in = WORD_BITS'(item_word);

    // every cell picks its neighbor, the new word, or itself
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_next[k] = cell_reg[k];
            if (cmd.shift_in) begin
                if (IW'(k) == cmd_pos) begin
                    cell_next[k] = word_in;
                end else if (k > 0 && IW'(k) > cmd_pos) begin
                    cell_next[k] = cell_reg[(k > 0) ? k - 1 : 0];
                end
            end else if (cmd.shift_out) begin
                if (k < DEPTH - 1 && IW'(k) >= cmd_pos) begin
                    cell_next[k] = cell_reg[(k < DEPTH - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_comb begin
        priority if (cmd.shift_in) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.shift_out) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_reg[k] <= cell_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign tail_idx = IW'(count_reg - CW'(1));
    assign head_ext = 64'(cell_reg[0]);
    assign tail_ext = 64'(cell_reg[tail_idx]);

    assign count     = count_reg;
    assign head_word = (count_reg == '0) ? '0 : head_ext[OUT_WORD_BITS-1:0];
    assign tail_word = (count_reg == '0) ? '0 : tail_ext[OUT_WORD_BITS-1:0];

endmodule
`default_nettype wire

// ===== hdl/indexed_insert_remove_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A word's result is valid the cycle after it is accepted.
// One word per cycle while m_tready takes each result; insert and remove shift all
// cells behind the position in parallel.
// A pending result that is taken frees the input in the same cycle.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module indexed_insert_remove_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // operation[1:0], position[6:2], item_word[38:7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // status[1:0], occupancy[6:2], head_word[38:7],
                                        // tail_word[70:39]
);
    import iirq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    op_t                     op;
    logic [POS_BITS-1:0]     position;
    logic [IN_WORD_BITS-1:0] item_word;
    logic [CW-1:0]           count;
    status_t                 status;
    cmd_t                    cmd;
    logic [IW-1:0]           cmd_pos;
    logic [OUT_WORD_BITS-1:0] head_word, tail_word;

    assign op        = op_t'(s_tdata[1:0]);
    assign position  = s_tdata[6:2];
    assign item_word = s_tdata[38:7];

    iirq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .position (position),
        .count    (count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .cmd_pos  (cmd_pos)
    );

    iirq_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_pos   (cmd_pos),
        .item_word (item_word),
        .count     (count),
        .head_word (head_word),
        .tail_word (tail_word)
    );

    assign m_tdata = {1'b0, tail_word, head_word, OCC_BITS'(count), status};

endmodule
`default_nettype wire
